### design/rbrs_pkg.sv
package rbrs_pkg;

  // Bin store geometry
  localparam int BIN_COUNT    = 46;
  localparam int PRODUCT_BITS = 48;
  localparam int COUNT_BITS   = 32;

  // RSSI mapping and window shape
  localparam int RSSI_LOW    = -90;
  localparam int START_RSSI  = -80;
  localparam int HALF_WINDOW = 4;
  localparam int WIN_LEN     = 2 * HALF_WINDOW + 1;
  localparam int FIRST_BIN   = START_RSSI - RSSI_LOW;

  // Derived widths
  localparam int ADDR_W  = $clog2(BIN_COUNT);
  localparam int IDX_W   = 10;
  localparam int PSUM_W  = PRODUCT_BITS + 4;
  localparam int CSUM_W  = COUNT_BITS + 4;
  localparam int MUL_A_W = 16;
  localparam int MUL_W   = CSUM_W + MUL_A_W;
  localparam int CMP_W   = (MUL_W > PSUM_W) ? MUL_W : PSUM_W;
  localparam int Q_W     = 16;
  localparam int BIT_W   = 4;

  typedef enum logic [1:0] {
    OP_RECORD  = 2'd0,
    OP_THRESH  = 2'd1,
    OP_AVERAGE = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REC_RD,
    ST_REC_WR,
    ST_RD,
    ST_ACC,
    ST_TW_MUL,
    ST_TW_CMP,
    ST_TB_CMP,
    ST_DV_MUL,
    ST_DV_CMP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [PRODUCT_BITS-1:0] prod;
    logic [COUNT_BITS-1:0]   cnt;
  } bin_t;

  typedef struct packed {
    op_e                op;
    logic signed [7:0]  rssi;
    logic        [15:0] rtt;
    logic        [15:0] pkt;
    logic        [15:0] thr;
    logic signed [7:0]  def_rssi;
  } item_t;

  typedef struct packed {
    logic signed [7:0]  result_rssi;
    logic        [15:0] avg_rtt;
    logic               found;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    bin_t              wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic               load;
    logic [MUL_A_W-1:0] a;
    logic [CSUM_W-1:0]  b;
    logic [CMP_W-1:0]   x;
  } mul_req_t;

endpackage

### design/rbrs_mem.sv
module rbrs_mem (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rbrs_pkg::mem_req_t req_i,
  output rbrs_pkg::bin_t     rdata_o
);

  rbrs_pkg::bin_t                     mem_q [rbrs_pkg::BIN_COUNT];
  rbrs_pkg::bin_t                     rdata_q;
  logic [rbrs_pkg::BIN_COUNT-1:0]     valid_q;
  logic                               rvalid_q;

  // Write and read the bin array, read data registered
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  // Track written bins so that reset reads as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvalid_q <= valid_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

### design/rbrs_mac.sv
module rbrs_mac (
  input  logic                         clk_i,
  input  rbrs_pkg::mul_req_t           req_i,
  output logic [rbrs_pkg::MUL_W-1:0]   prod_o,
  output logic                         le_o
);

  logic [rbrs_pkg::MUL_W-1:0] prod_d, prod_q;

  // Multiply into the product register
  assign prod_d = rbrs_pkg::MUL_W'(req_i.a) * rbrs_pkg::MUL_W'(req_i.b);

  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      prod_q <= prod_d;
    end
  end

  // Compare the held product against the operand of this cycle
  assign le_o   = rbrs_pkg::CMP_W'(prod_q) <= req_i.x;
  assign prod_o = prod_q;

endmodule

### design/rbrs_ctrl.sv
module rbrs_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  rbrs_pkg::item_t            in_item_i,
  output logic                       idle_o,
  input  logic                       out_free_i,
  output logic                       done_o,
  output rbrs_pkg::result_t          result_o,
  output rbrs_pkg::mem_req_t         mem_req_o,
  input  rbrs_pkg::bin_t             mem_rdata_i,
  output rbrs_pkg::mul_req_t         mul_req_o,
  input  logic [rbrs_pkg::MUL_W-1:0] mul_prod_i,
  input  logic                       mul_le_i
);

  localparam int ADDR_W = rbrs_pkg::ADDR_W;
  localparam int IDX_W  = rbrs_pkg::IDX_W;
  localparam int PSUM_W = rbrs_pkg::PSUM_W;
  localparam int CSUM_W = rbrs_pkg::CSUM_W;
  localparam int PB     = rbrs_pkg::PRODUCT_BITS;
  localparam int CB     = rbrs_pkg::COUNT_BITS;
  localparam int Q_W    = rbrs_pkg::Q_W;
  localparam int BIT_W  = rbrs_pkg::BIT_W;
  localparam int WL     = rbrs_pkg::WIN_LEN;
  localparam int HW     = rbrs_pkg::HALF_WINDOW;

  rbrs_pkg::state_e   state_q, state_d;
  rbrs_pkg::op_e      op_q, op_d;
  logic [15:0]        rtt_q, rtt_d;
  logic [15:0]        pkt_q, pkt_d;
  logic [15:0]        thr_q, thr_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [ADDR_W-1:0]  last_q, last_d;
  logic [PSUM_W-1:0]  psum_q, psum_d;
  logic [CSUM_W-1:0]  csum_q, csum_d;
  logic [Q_W-1:0]     q_q, q_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  rbrs_pkg::result_t  res_q, res_d;
  rbrs_pkg::bin_t     line_q [WL];
  rbrs_pkg::bin_t     line_d [WL];

  logic                    accept;
  logic signed [IDX_W-1:0] idx, lo_s, hi_s;
  logic [ADDR_W-1:0]       rec_addr, avg_lo, avg_hi;
  logic [PSUM_W-1:0]       acc_p;
  logic [CSUM_W-1:0]       acc_c;
  logic [Q_W-1:0]          trial;
  logic                    last_r;
  logic                    prefill;
  logic                    bin_empty;
  logic [PB:0]             rec_p;
  logic [CB:0]             rec_c;
  logic                    rec_wrap;
  rbrs_pkg::bin_t          rec_bin;

  assign accept = in_valid_i && (state_q == rbrs_pkg::ST_IDLE);

  // Map the RSSI onto a bin index and clamp it for records and averages
  always_comb begin
    idx  = {{(IDX_W-8){in_item_i.rssi[7]}}, in_item_i.rssi} + IDX_W'(-rbrs_pkg::RSSI_LOW);
    lo_s = idx - IDX_W'(HW);
    hi_s = idx + IDX_W'(HW);
    if (idx < 0) begin
      rec_addr = '0;
    end else if (idx > $signed(IDX_W'(rbrs_pkg::BIN_COUNT - 1))) begin
      rec_addr = ADDR_W'(rbrs_pkg::BIN_COUNT - 1);
    end else begin
      rec_addr = ADDR_W'(idx);
    end
    if (lo_s < 0) begin
      avg_lo = '0;
      avg_hi = ADDR_W'(HW);
    end else if (hi_s > $signed(IDX_W'(rbrs_pkg::BIN_COUNT - 1))) begin
      avg_lo = ADDR_W'(rbrs_pkg::BIN_COUNT - 1 - HW);
      avg_hi = ADDR_W'(rbrs_pkg::BIN_COUNT - 1);
    end else begin
      avg_lo = ADDR_W'(lo_s);
      avg_hi = ADDR_W'(hi_s);
    end
  end

  // Slide the window: add the bin just read, drop the oldest
  assign acc_p = psum_q + PSUM_W'(mem_rdata_i.prod) - PSUM_W'(line_q[WL-1].prod);
  assign acc_c = csum_q + CSUM_W'(mem_rdata_i.cnt) - CSUM_W'(line_q[WL-1].cnt);

  assign trial     = q_q | (Q_W'(1) << bit_q);
  assign last_r    = addr_q == ADDR_W'(rbrs_pkg::BIN_COUNT - 1);
  assign prefill   = addr_q < ADDR_W'(rbrs_pkg::FIRST_BIN + HW);
  assign bin_empty = line_q[HW].cnt == '0;

  // Add the sample, restart the bin if either sum carries out
  always_comb begin
    rec_p    = {1'b0, mem_rdata_i.prod} + (PB+1)'(mul_prod_i);
    rec_c    = {1'b0, mem_rdata_i.cnt} + (CB+1)'(pkt_q);
    rec_wrap = rec_p[PB] | rec_c[CB];
    if (rec_wrap) begin
      rec_bin.prod = PB'(mul_prod_i);
      rec_bin.cnt  = CB'(pkt_q);
    end else begin
      rec_bin.prod = rec_p[PB-1:0];
      rec_bin.cnt  = rec_c[CB-1:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rbrs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (in_item_i.op)
            rbrs_pkg::OP_RECORD: begin
              state_d = (in_item_i.pkt == '0) ? rbrs_pkg::ST_DONE : rbrs_pkg::ST_REC_RD;
            end
            rbrs_pkg::OP_THRESH:  state_d = rbrs_pkg::ST_RD;
            rbrs_pkg::OP_AVERAGE: state_d = rbrs_pkg::ST_RD;
            default:              state_d = rbrs_pkg::ST_DONE;
          endcase
        end
      end
      rbrs_pkg::ST_REC_RD: state_d = rbrs_pkg::ST_REC_WR;
      rbrs_pkg::ST_REC_WR: state_d = rbrs_pkg::ST_DONE;
      rbrs_pkg::ST_RD:     state_d = rbrs_pkg::ST_ACC;
      rbrs_pkg::ST_ACC: begin
        if (op_q == rbrs_pkg::OP_AVERAGE) begin
          if (addr_q != last_q) begin
            state_d = rbrs_pkg::ST_RD;
          end else if (acc_p == '0 || acc_c == '0) begin
            state_d = rbrs_pkg::ST_DONE;
          end else begin
            state_d = rbrs_pkg::ST_DV_MUL;
          end
        end else begin
          state_d = prefill ? rbrs_pkg::ST_RD : rbrs_pkg::ST_TW_MUL;
        end
      end
      rbrs_pkg::ST_TW_MUL: begin
        if (csum_q != '0) begin
          state_d = rbrs_pkg::ST_TW_CMP;
        end else begin
          state_d = last_r ? rbrs_pkg::ST_DONE : rbrs_pkg::ST_RD;
        end
      end
      rbrs_pkg::ST_TW_CMP: begin
        if (!mul_le_i && !bin_empty) begin
          state_d = rbrs_pkg::ST_TB_CMP;
        end else begin
          state_d = last_r ? rbrs_pkg::ST_DONE : rbrs_pkg::ST_RD;
        end
      end
      rbrs_pkg::ST_TB_CMP: begin
        if (!mul_le_i || last_r) begin
          state_d = rbrs_pkg::ST_DONE;
        end else begin
          state_d = rbrs_pkg::ST_RD;
        end
      end
      rbrs_pkg::ST_DV_MUL: state_d = rbrs_pkg::ST_DV_CMP;
      rbrs_pkg::ST_DV_CMP: begin
        state_d = (bit_q == '0) ? rbrs_pkg::ST_DONE : rbrs_pkg::ST_DV_MUL;
      end
      rbrs_pkg::ST_DONE: begin
        if (out_free_i) begin
          state_d = rbrs_pkg::ST_IDLE;
        end
      end
      default: state_d = rbrs_pkg::ST_IDLE;
    endcase
  end

  // Drive the memory port and the shared multiply-compare unit
  always_comb begin
    mem_req_o       = '0;
    mem_req_o.waddr = addr_q;
    mem_req_o.wdata = rec_bin;
    mem_req_o.raddr = addr_q;
    mul_req_o       = '0;
    idle_o          = 1'b0;
    done_o          = 1'b0;
    case (state_q)
      rbrs_pkg::ST_IDLE: idle_o = 1'b1;
      rbrs_pkg::ST_REC_RD: begin
        mem_req_o.re   = 1'b1;
        mul_req_o.load = 1'b1;
        mul_req_o.a    = rtt_q;
        mul_req_o.b    = CSUM_W'(pkt_q);
      end
      rbrs_pkg::ST_REC_WR: mem_req_o.we = 1'b1;
      rbrs_pkg::ST_RD:     mem_req_o.re = 1'b1;
      rbrs_pkg::ST_TW_MUL: begin
        mul_req_o.load = 1'b1;
        mul_req_o.a    = thr_q;
        mul_req_o.b    = csum_q;
      end
      rbrs_pkg::ST_TW_CMP: begin
        mul_req_o.load = 1'b1;
        mul_req_o.a    = thr_q;
        mul_req_o.b    = CSUM_W'(line_q[HW].cnt);
        mul_req_o.x    = rbrs_pkg::CMP_W'(psum_q);
      end
      rbrs_pkg::ST_TB_CMP: mul_req_o.x = rbrs_pkg::CMP_W'(line_q[HW].prod);
      rbrs_pkg::ST_DV_MUL: begin
        mul_req_o.load = 1'b1;
        mul_req_o.a    = trial;
        mul_req_o.b    = csum_q;
      end
      rbrs_pkg::ST_DV_CMP: mul_req_o.x = rbrs_pkg::CMP_W'(psum_q);
      rbrs_pkg::ST_DONE:   done_o = 1'b1;
      default: ;
    endcase
  end

  // Datapath next values
  always_comb begin
    op_d   = op_q;
    rtt_d  = rtt_q;
    pkt_d  = pkt_q;
    thr_d  = thr_q;
    addr_d = addr_q;
    last_d = last_q;
    psum_d = psum_q;
    csum_d = csum_q;
    q_d    = q_q;
    bit_d  = bit_q;
    res_d  = res_q;
    for (int i = 0; i < WL; i++) begin
      line_d[i] = line_q[i];
    end
    case (state_q)
      rbrs_pkg::ST_IDLE: begin
        if (accept) begin
          op_d   = in_item_i.op;
          rtt_d  = in_item_i.rtt;
          pkt_d  = in_item_i.pkt;
          thr_d  = in_item_i.thr;
          psum_d = '0;
          csum_d = '0;
          q_d    = '0;
          bit_d  = BIT_W'(Q_W - 1);
          res_d  = '0;
          for (int i = 0; i < WL; i++) begin
            line_d[i] = '0;
          end
          case (in_item_i.op)
            rbrs_pkg::OP_RECORD: addr_d = rec_addr;
            rbrs_pkg::OP_THRESH: begin
              addr_d            = ADDR_W'(rbrs_pkg::FIRST_BIN);
              res_d.result_rssi = in_item_i.def_rssi;
            end
            rbrs_pkg::OP_AVERAGE: begin
              addr_d = avg_lo;
              last_d = avg_hi;
            end
            default: ;
          endcase
        end
      end
      rbrs_pkg::ST_ACC: begin
        line_d[0] = mem_rdata_i;
        for (int i = 1; i < WL; i++) begin
          line_d[i] = line_q[i-1];
        end
        psum_d = acc_p;
        csum_d = acc_c;
        if (op_q == rbrs_pkg::OP_AVERAGE) begin
          if (addr_q != last_q) begin
            addr_d = addr_q + ADDR_W'(1);
          end
        end else if (prefill) begin
          addr_d = addr_q + ADDR_W'(1);
        end
      end
      rbrs_pkg::ST_TW_MUL: begin
        if (csum_q == '0 && !last_r) begin
          addr_d = addr_q + ADDR_W'(1);
        end
      end
      rbrs_pkg::ST_TW_CMP: begin
        if (!(!mul_le_i && !bin_empty) && !last_r) begin
          addr_d = addr_q + ADDR_W'(1);
        end
      end
      rbrs_pkg::ST_TB_CMP: begin
        if (!mul_le_i) begin
          res_d.found       = 1'b1;
          res_d.result_rssi = 8'(IDX_W'(addr_q) + IDX_W'(rbrs_pkg::RSSI_LOW - HW));
        end else if (!last_r) begin
          addr_d = addr_q + ADDR_W'(1);
        end
      end
      rbrs_pkg::ST_DV_CMP: begin
        if (mul_le_i) begin
          q_d = trial;
        end
        bit_d = bit_q - BIT_W'(1);
        if (bit_q == '0) begin
          res_d.avg_rtt = mul_le_i ? trial : q_q;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rbrs_pkg::ST_IDLE;
      op_q    <= rbrs_pkg::OP_NONE;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rtt_q  <= rtt_d;
    pkt_q  <= pkt_d;
    thr_q  <= thr_d;
    addr_q <= addr_d;
    last_q <= last_d;
    psum_q <= psum_d;
    csum_q <= csum_d;
    q_q    <= q_d;
    bit_q  <= bit_d;
    res_q  <= res_d;
    for (int i = 0; i < WL; i++) begin
      line_q[i] <= line_d[i];
    end
  end

  assign result_o = res_q;

endmodule

### design/rssi_binned_rtt_statistics.sv
// RSSI-binned RTT statistics.
// Input words arrive on the s_axis group: tuser carries the operation (record a
// sample, threshold query, average query), tdata the operands. Every input word
// gives exactly one output word on the m_axis group, records and unused codes
// included (their result fields read zero).
// The block handles one word at a time; s_axis_tready is low while a word is
// being worked on. A record reads its bin and writes it back, or goes straight
// to the output when the packet count is zero or the code is unused. An average
// query sums a window of 5 or 9 bins, then divides when both sums are non-zero;
// a threshold query steps through up to 32 candidate bins until one passes or
// the last bin is reached. The work runs through the single read port of the bin
// memory and through the one multiply-compare unit, which the record, the
// threshold test and the 16-step bit-serial average division all share.
// The output register holds a finished word until the receiver takes it; if it is
// still full when the next result is ready, the sequencer waits in its final state.
// Reset empties all bins at once (per-bin valid flags) and leaves the block idle.
module rssi_binned_rtt_statistics (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] rssi, [23:8] rtt, [39:24] packet_count, [55:40] rtt_threshold,
  // [63:56] default_rssi
  input  logic [63:0] s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] result_rssi, [23:8] avg_rtt, [24] found, [31:25] zero
  output logic [31:0] m_axis_tdata
);

  rbrs_pkg::item_t                item;
  rbrs_pkg::result_t              result;
  rbrs_pkg::result_t              out_q, out_d;
  logic                           out_valid_q, out_valid_d;
  logic                           out_free;
  logic                           done;
  logic                           idle;
  rbrs_pkg::mem_req_t             mem_req;
  rbrs_pkg::bin_t                 mem_rdata;
  rbrs_pkg::mul_req_t             mul_req;
  logic [rbrs_pkg::MUL_W-1:0]     mul_prod;
  logic                           mul_le;

  // Unpack the input word
  assign item.op       = rbrs_pkg::op_e'(s_axis_tuser);
  assign item.rssi     = s_axis_tdata[7:0];
  assign item.rtt      = s_axis_tdata[23:8];
  assign item.pkt      = s_axis_tdata[39:24];
  assign item.thr      = s_axis_tdata[55:40];
  assign item.def_rssi = s_axis_tdata[63:56];

  assign s_axis_tready = idle;

  rbrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_item_i   (item),
    .idle_o      (idle),
    .out_free_i  (out_free),
    .done_o      (done),
    .result_o    (result),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .mul_req_o   (mul_req),
    .mul_prod_i  (mul_prod),
    .mul_le_i    (mul_le)
  );

  rbrs_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  rbrs_mac u_mac (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (mul_prod),
    .le_o   (mul_le)
  );

  // Hold the result word until the receiver takes it
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (done && out_free) begin
      out_d       = result;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q.found, out_q.avg_rtt, out_q.result_rssi};

endmodule

### design/rbrs_chk.sv
module rbrs_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // Hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

  // Drop ready for the word after an acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word taken while busy");

  // A fresh result only follows a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without work in progress");

  // A found bin lies in the searched range and carries no average
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[24] |->
      $signed(m_axis_tdata[7:0]) >= rbrs_pkg::START_RSSI &&
      $signed(m_axis_tdata[7:0]) <=
        rbrs_pkg::RSSI_LOW + rbrs_pkg::BIN_COUNT - 1 - rbrs_pkg::HALF_WINDOW &&
      m_axis_tdata[23:8] == 16'd0)
    else $error("found result out of range");

endmodule

bind rssi_binned_rtt_statistics rbrs_chk u_rbrs_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
